// ----- rtl/length_prefix_deframer_assert.svh -----
// Assertion macros used by the checker of the deframer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef LENGTH_PREFIX_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIX_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define LPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lpd_pkg.sv -----
`default_nettype none

package lpd_pkg;

  localparam int unsigned LenW = 32;
  localparam logic [LenW-1:0] MaxLenReset = 32'd10485760;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } lpd_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       datagram_end;
  } lpd_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_start;
    logic       frame_end;
    logic       oversize_drop;
  } lpd_result_t;

  typedef struct packed {
    logic        valid;
    lpd_result_t res;
  } lpd_push_t;

endpackage

`default_nettype wire

// ----- rtl/lpd_in_if.sv -----
`default_nettype none

interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       datagram_end;

  modport source (output valid, output data_byte, output datagram_end, input ready);
  modport sink (input valid, input data_byte, input datagram_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/lpd_out_if.sv -----
`default_nettype none

interface lpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       frame_start;
  logic       frame_end;
  logic       oversize_drop;

  modport source (output valid, output payload_byte, output frame_start,
                  output frame_end, output oversize_drop, input ready);
  modport sink (input valid, input payload_byte, input frame_start,
                input frame_end, input oversize_drop, output ready);
endinterface

`default_nettype wire

// ----- rtl/lpd_in_stage.sv -----
`default_nettype none

module lpd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lpd_pkg::lpd_item_t in_item,
  input  wire logic              consume,
  output logic                   item_valid,
  output lpd_pkg::lpd_item_t     item
);

  logic               vld_r, vld_nxt;
  lpd_pkg::lpd_item_t item_r;
  logic               accept;

  // The stage takes a new request whenever it is empty or its contents leave in the same cycle.
  assign in_ready = rst_n & (~vld_r | consume);
  assign accept   = in_valid & in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (consume) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- rtl/lpd_core.sv -----
`default_nettype none

module lpd_core #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata,
  input  wire logic               item_valid,
  input  wire lpd_pkg::lpd_item_t item,
  input  wire logic               out_take,
  output logic                    consume,
  output lpd_pkg::lpd_push_t      push
);

  localparam int unsigned CntW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [CntW-1:0] HdrLast = CntW'(HEADER_BYTES - 1);

  logic [31:0]         max_len_r;
  lpd_pkg::lpd_phase_t phase_r, phase_nxt;
  logic [CntW-1:0]     hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]         shift_r, shift_nxt;
  logic [31:0]         remain_r, remain_nxt;
  logic                high_r, high_nxt;
  logic                first_r, first_nxt;

  logic [31:0] shift_in;
  logic        high_in;
  logic        hdr_done;
  logic        len_zero;
  logic        len_over;
  logic        pay_last;

  assign consume = item_valid & out_take;

  // Header decode shared by the next-state and datapath logic.
  always_comb begin
    shift_in = {shift_r[23:0], item.data_byte};
    high_in  = high_r | (shift_r[31:24] != 8'd0);
    hdr_done = (hdr_cnt_r == HdrLast);
    len_zero = ~high_in & (shift_in == 32'd0);
    len_over = high_in | (shift_in > max_len_r);
    pay_last = (remain_r <= 32'd1);
  end

  always_comb begin
    phase_nxt = phase_r;
    if (consume) begin
      unique case (phase_r)
        lpd_pkg::PH_PAYLOAD: begin
          if (pay_last) begin
            phase_nxt = lpd_pkg::PH_HEADER;
          end
        end
        lpd_pkg::PH_DISCARD: begin
          if (item.datagram_end) begin
            phase_nxt = lpd_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_nxt = lpd_pkg::PH_HEADER;
          if (hdr_done && !len_zero) begin
            if (len_over) begin
              phase_nxt = item.datagram_end ? lpd_pkg::PH_HEADER : lpd_pkg::PH_DISCARD;
            end else begin
              phase_nxt = lpd_pkg::PH_PAYLOAD;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    hdr_cnt_nxt = hdr_cnt_r;
    shift_nxt   = shift_r;
    remain_nxt  = remain_r;
    high_nxt    = high_r;
    first_nxt   = first_r;
    push        = '0;
    if (consume) begin
      unique case (phase_r)
        lpd_pkg::PH_PAYLOAD: begin
          push.valid            = 1'b1;
          push.res.payload_byte = item.data_byte;
          push.res.frame_start  = first_r;
          push.res.frame_end    = pay_last;
          first_nxt             = 1'b0;
          remain_nxt            = pay_last ? 32'd0 : (remain_r - 32'd1);
        end
        lpd_pkg::PH_DISCARD: begin
          push.valid = 1'b0;
        end
        default: begin
          if (hdr_done) begin
            hdr_cnt_nxt = '0;
            shift_nxt   = '0;
            high_nxt    = 1'b0;
            if (!len_zero) begin
              if (len_over) begin
                push.valid             = 1'b1;
                push.res.oversize_drop = 1'b1;
              end else begin
                remain_nxt = shift_in;
                first_nxt  = 1'b1;
              end
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + CntW'(1);
            shift_nxt   = shift_in;
            high_nxt    = high_in;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpd_pkg::MaxLenReset;
      phase_r   <= lpd_pkg::PH_HEADER;
      hdr_cnt_r <= '0;
      shift_r   <= '0;
      remain_r  <= '0;
      high_r    <= 1'b0;
      first_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      shift_r   <= shift_nxt;
      remain_r  <= remain_nxt;
      high_r    <= high_nxt;
      first_r   <= first_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpd_out_stage.sv -----
`default_nettype none

module lpd_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lpd_pkg::lpd_push_t push,
  output logic                    out_take,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lpd_pkg::lpd_result_t    out_res
);

  logic                 vld_r, vld_nxt;
  lpd_pkg::lpd_result_t res_r;

  // The result register refills when it is empty or in the cycle its request is taken downstream.
  assign out_take = ~vld_r | out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (out_take) begin
      vld_nxt = push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && push.valid) begin
      res_r <= push.res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ----- rtl/length_prefix_deframer.sv -----
// A request accepted into the input stage register is decoded by the core, and its
// result, if any, is registered in the result register, from which it is taken.
// Throughput: one request per cycle, sustained while the result side keeps up.
// A stalled result register holds the input stage; ready follows it combinationally.
// Reset (synchronous, active low) returns to header collection, drops pending
// requests and restores the maximum payload length to 10 MiB; ready is low in reset.
`default_nettype none

module length_prefix_deframer #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lpd_in_if.sink           in_ch,
  lpd_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  lpd_pkg::lpd_item_t   in_item;
  lpd_pkg::lpd_item_t   item;
  lpd_pkg::lpd_push_t   push;
  lpd_pkg::lpd_result_t out_res;
  logic                 item_valid;
  logic                 consume;
  logic                 out_take;

  assign in_item.data_byte    = in_ch.data_byte;
  assign in_item.datagram_end = in_ch.datagram_end;

  lpd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  lpd_core #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item       (item),
    .out_take   (out_take),
    .consume    (consume),
    .push       (push)
  );

  lpd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .out_take  (out_take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.frame_start   = out_res.frame_start;
  assign out_ch.frame_end     = out_res.frame_end;
  assign out_ch.oversize_drop = out_res.oversize_drop;

endmodule

`default_nettype wire

// ----- rtl/lpd_checker.sv -----
`default_nettype none
`include "length_prefix_deframer_assert.svh"

module lpd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] payload_byte,
  input wire logic       frame_start,
  input wire logic       frame_end,
  input wire logic       oversize_drop
);

  // A stalled result keeps its request on offer.
  `LPD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // An oversize report carries no frame marks and a zero byte.
  `LPD_ASSERT_IMP(a_drop_clean, out_valid && oversize_drop,
                  !frame_start && !frame_end && payload_byte == 8'd0,
                  "oversize report with frame marks or data")

  // A result appearing on an empty output comes from an accepted request.
  `LPD_ASSERT_IMP(a_out_cause, $rose(out_valid), $past(in_valid && in_ready, 2),
                  "result without an accepted request")

endmodule

bind length_prefix_deframer lpd_checker u_lpd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_byte  (out_ch.payload_byte),
  .frame_start   (out_ch.frame_start),
  .frame_end     (out_ch.frame_end),
  .oversize_drop (out_ch.oversize_drop)
);

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  import lpd_pkg::*;

  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned LIMIT       = 400000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  lpd_in_if  in_ch();
  lpd_out_if out_ch();

  length_prefix_deframer #(.HEADER_BYTES(HDR_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stream bytes waiting to be offered, and decoded results still to arrive.
  lpd_item_t   pending_bytes[$];
  lpd_result_t expected_results[$];

  int          items_left    = 0;
  int          queued_count  = 0;
  int          errors        = 0;
  int          cycle_cnt     = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          in_taken      = 1'b0;
  bit          hold_off_req  = 1'b0;
  int          hold_left     = 0;
  logic [31:0] gen_max       = MaxLenReset;

  // Decoder state, mirroring the block.
  lpd_phase_t  dec_phase    = PH_HEADER;
  int unsigned dec_hdr_cnt  = 0;
  logic [31:0] dec_len      = '0;
  bit          dec_len_high = 1'b0;
  logic [31:0] dec_left     = '0;
  bit          dec_first    = 1'b0;
  logic [31:0] dec_max      = MaxLenReset;

  function automatic bit decode_byte(input lpd_item_t req, output lpd_result_t res);
    logic [31:0] len;
    bit          high;
    res = '0;
    if (dec_phase == PH_PAYLOAD) begin
      res.payload_byte = req.data_byte;
      res.frame_start  = dec_first;
      res.frame_end    = (dec_left <= 32'd1);
      dec_first = 1'b0;
      if (res.frame_end) begin
        dec_left  = '0;
        dec_phase = PH_HEADER;
      end else begin
        dec_left = dec_left - 32'd1;
      end
      return 1'b1;
    end
    if (dec_phase == PH_DISCARD) begin
      if (req.datagram_end) begin
        dec_phase = PH_HEADER;
      end
      return 1'b0;
    end
    dec_phase = PH_HEADER;
    // A nonzero byte shifted out of the low 32 bits makes the length oversize.
    if (dec_len[31:24] != 8'd0) begin
      dec_len_high = 1'b1;
    end
    dec_len = {dec_len[23:0], req.data_byte};
    dec_hdr_cnt++;
    if (dec_hdr_cnt < HDR_BYTES) begin
      return 1'b0;
    end
    len          = dec_len;
    high         = dec_len_high;
    dec_hdr_cnt  = 0;
    dec_len      = '0;
    dec_len_high = 1'b0;
    if (!high && len == 32'd0) begin
      return 1'b0;
    end
    if (high || len > dec_max) begin
      dec_phase         = req.datagram_end ? PH_HEADER : PH_DISCARD;
      res.oversize_drop = 1'b1;
      return 1'b1;
    end
    dec_left  = len;
    dec_first = 1'b1;
    dec_phase = PH_PAYLOAD;
    return 1'b0;
  endfunction

  // Sender: a request stays offered until it is taken.
  always @(negedge clk) begin
    lpd_item_t req;
    if (!in_ch.valid || in_taken) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req = pending_bytes.pop_front();
        in_ch.valid        <= 1'b1;
        in_ch.data_byte    <= req.data_byte;
        in_ch.datagram_end <= req.datagram_end;
      end else begin
        in_ch.valid        <= 1'b0;
        in_ch.data_byte    <= 8'($urandom);
        in_ch.datagram_end <= 1'($urandom);
      end
    end
  end

  // Receiver, with its own count for the long hold-off.
  always @(negedge clk) begin
    logic rdy;
    if (hold_off_req) begin
      hold_left    = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else begin
      rdy = ($urandom_range(99) >= recv_idle_pct);
    end
    out_ch.ready <= rdy;
  end

  always @(posedge clk) begin
    lpd_item_t   req;
    lpd_result_t got;
    lpd_result_t want;
    lpd_result_t res;
    in_taken = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        dec_max = cfg_wdata;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.payload_byte  = out_ch.payload_byte;
        got.frame_start   = out_ch.frame_start;
        got.frame_end     = out_ch.frame_end;
        got.oversize_drop = out_ch.oversize_drop;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result byte %02h start %b end %b drop %b", $time,
                   got.payload_byte, got.frame_start, got.frame_end, got.oversize_drop);
        end else begin
          want = expected_results.pop_front();
          if (got.payload_byte !== want.payload_byte || got.frame_start !== want.frame_start
              || got.frame_end !== want.frame_end
              || got.oversize_drop !== want.oversize_drop) begin
            errors++;
            $display("%0t: expected byte %02h start %b end %b drop %b, got byte %02h start %b end %b drop %b",
                     $time, want.payload_byte, want.frame_start, want.frame_end,
                     want.oversize_drop, got.payload_byte, got.frame_start, got.frame_end,
                     got.oversize_drop);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        req.data_byte    = in_ch.data_byte;
        req.datagram_end = in_ch.datagram_end;
        if (decode_byte(req, res)) begin
          expected_results.push_back(res);
        end
        in_taken = 1'b1;
        items_left--;
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic dend);
    lpd_item_t req;
    req.data_byte    = b;
    req.datagram_end = dend;
    pending_bytes.push_back(req);
    items_left++;
    queued_count++;
  endtask

  // The first byte sent is the most significant; dends[0] goes with the last one.
  task automatic push_header(input logic [31:0] len, input logic [3:0] dends);
    for (int i = 3; i >= 0; i--) begin
      push_byte(len[i*8 +: 8], dends[i]);
    end
  endtask

  function automatic logic [3:0] rand_dends();
    logic [3:0] d;
    for (int i = 0; i < 4; i++) begin
      d[i] = ($urandom_range(9) == 0);
    end
    return d;
  endfunction

  task automatic good_frame(input logic [31:0] len);
    push_header(len, rand_dends());
    for (int i = 0; i < int'(len); i++) begin
      push_byte(8'($urandom), $urandom_range(9) == 0);
    end
  endtask

  task automatic oversize_frame(input logic [31:0] len);
    logic [3:0] d;
    d    = rand_dends();
    d[0] = ($urandom_range(9) < 3);
    push_header(len, d);
    if (!d[0]) begin
      repeat ($urandom_range(8)) push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic random_unit();
    int          pick;
    int unsigned cap;
    int unsigned short_cap;
    longint      lo;
    logic [31:0] v;
    pick      = $urandom_range(99);
    cap       = (gen_max < 32'd64) ? int'(gen_max) : 64;
    short_cap = (cap < 12) ? cap : 12;
    if (pick < 55 && cap > 0) begin
      good_frame(($urandom_range(4) == 0) ? $urandom_range(cap, 1)
                                          : $urandom_range(short_cap, 1));
    end else if (pick < 65) begin
      push_header(32'd0, rand_dends());
    end else if (pick < 85 && gen_max != 32'hFFFF_FFFF) begin
      lo = longint'(gen_max) + 1;
      case ($urandom_range(2))
        0:       oversize_frame(32'(lo));
        1:       oversize_frame(32'hFFFF_FFFF);
        default: oversize_frame(32'(lo + ({$urandom} % (64'h1_0000_0000 - lo))));
      endcase
    end else begin
      // Arbitrary header bytes; long accepted lengths are folded back to short frames.
      v = $urandom;
      if (v > gen_max) begin
        oversize_frame(v);
      end else if (v == 32'd0) begin
        push_header(v, rand_dends());
      end else if (v <= 32'd64) begin
        good_frame(v);
      end else begin
        good_frame((v % 64) + 1);
      end
    end
  endtask

  task automatic stream_units(input int n);
    int target;
    target = queued_count + n;
    while (queued_count < target) begin
      random_unit();
    end
  endtask

  // Wait until every request is taken and every result has come, then let the
  // pipeline settle, since the last requests may have caused no result.
  task automatic drain();
    while (items_left != 0 || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max(input logic [31:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    gen_max    = v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.data_byte    = '0;
    in_ch.datagram_end = 1'b0;
    out_ch.ready       = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 76;

    // Single-byte frame of zero, then a zero length with datagram ends inside it.
    push_header(32'd1, 4'b0000);
    push_byte(8'h00, 1'b0);
    push_header(32'd0, 4'b0101);
    // Two bytes of all ones; datagram ends in header and payload are ignored.
    push_header(32'd2, 4'b0100);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    // Largest header, ending its datagram: report, then straight back to headers.
    push_header(32'hFFFF_FFFF, 4'b0001);
    // Just above the limit: report, then discard up to the datagram end.
    push_header(MaxLenReset + 32'd1, 4'b0000);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b1);
    push_header(32'd3, 4'b0000);
    push_byte(8'h80, 1'b1);
    push_byte(8'h01, 1'b1);
    push_byte(8'h7F, 1'b0);
    drain();

    write_max(32'd0);
    stream_units(150);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    write_max(32'hFFFF_FFFF);
    hold_off_req = 1'b1;
    stream_units(350);
    drain();

    send_idle_pct = 76;
    recv_idle_pct = 28;
    write_max(32'd5);
    stream_units(200);
    // Sender pause until every result is in, with no register change.
    drain();
    stream_units(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max(32'd40);
    stream_units(350);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
